/* src/snsd_pkg.sv */
// Shared types, constants and helper functions for the stereo noise-shaped dither block.
// Used by snsd_cell, snsd_quant, the top level and the port checker.
package snsd_pkg;

    localparam int SAMPLE_BITS     = 24;
    localparam int STAGES_DEF      = 16;
    localparam int STAGES_MAX      = 32;
    localparam int ST_W            = 40;
    localparam int ACC_W           = 42;
    localparam int CNT_W           = $clog2(STAGES_MAX + 4);
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 64;

    localparam logic [39:0] SCALE_RST = 40'd2147483648;
    localparam logic [37:0] RECIP_RST = 38'd33554432;
    localparam logic [31:0] SEED_L_RST = 32'd2463534242;
    localparam logic [31:0] SEED_R_RST = 32'd123456789;

    localparam logic signed [40:0] K_097  = 41'sd4166118277;
    localparam logic signed [20:0] K_0475 = 21'sd498074;

    localparam logic signed [63:0] ST_MAX = 64'sd549755813887;
    localparam logic signed [63:0] ST_MIN = -64'sd549755813888;
    localparam logic signed [63:0] LEVEL_LIM = 64'sd16777216;

    typedef enum logic [1:0] {
        REG_SCALE  = 2'd0,
        REG_RECIP  = 2'd1,
        REG_SEED_L = 2'd2,
        REG_SEED_R = 2'd3
    } t_reg;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
        logic                          block_end;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_dithered;
        logic signed [SAMPLE_BITS-1:0] right_dithered;
        logic                          block_end_out;
    } t_out;

    typedef struct packed {
        logic             load;
        logic             run;
        logic [CNT_W-1:0] cnt;
    } t_seq;

    function automatic logic [31:0] xs_step(input logic [31:0] r);
        logic [31:0] x;
        x = r ^ (r << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

    // r - 2^31 as a signed Q32 value
    function automatic logic signed [31:0] noise(input logic [31:0] r);
        return {~r[31], r[30:0]};
    endfunction

    function automatic logic signed [ST_W-1:0] sat40(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v;
        if (v > ST_MAX) t = ST_MAX;
        if (v < ST_MIN) t = ST_MIN;
        return t[ST_W-1:0];
    endfunction

endpackage

/* src/snsd_cell.sv */
// One half-average high-pass shaper stage: holds its stage value, hands the
// running sum and the generator state to the next stage. Depends on snsd_pkg.
module snsd_cell #(
    parameter bit LAST = 1'b0
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_vld,
    input  logic signed [snsd_pkg::ACC_W-1:0]    i_acc,
    input  logic [31:0]                          i_rng,
    output logic                                 o_vld,
    output logic signed [snsd_pkg::ACC_W-1:0]    o_acc,
    output logic [31:0]                          o_rng
);

    logic signed [snsd_pkg::ST_W-1:0]  r_sh,  n_sh;
    logic signed [snsd_pkg::ACC_W-1:0] r_acc, n_acc;
    logic [31:0]                       r_rng, n_rng;
    logic                              r_vld;
    logic signed [snsd_pkg::ACC_W:0]   w_sum;
    logic signed [snsd_pkg::ACC_W:0]   w_half;
    logic signed [31:0]                w_nz;

    always_comb begin
        w_sum  = {{3{r_sh[snsd_pkg::ST_W-1]}}, r_sh} + {i_acc[snsd_pkg::ACC_W-1], i_acc};
        w_half = w_sum >>> 1;
        n_sh   = snsd_pkg::sat40({{(64-snsd_pkg::ACC_W-1){w_half[snsd_pkg::ACC_W]}}, w_half});
        n_rng  = LAST ? i_rng : snsd_pkg::xs_step(i_rng);
        w_nz   = LAST ? 32'sd0 : snsd_pkg::noise(n_rng);
        n_acc  = i_acc - {{2{n_sh[snsd_pkg::ST_W-1]}}, n_sh}
                 + {{(snsd_pkg::ACC_W-32){w_nz[31]}}, w_nz};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh  <= '0;
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
            if (i_vld) begin
                r_sh <= n_sh;
            end
        end
    end

    // hold the handed-on values between requests
    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_acc <= n_acc;
            r_rng <= n_rng;
        end
    end

    assign o_vld = r_vld;
    assign o_acc = r_acc;
    assign o_rng = r_rng;

endmodule

/* src/snsd_quant.sv */
// Per-channel back end: input scaling, odd-error feedback, floor, error
// memory and output rescale, one multiply per step. Depends on snsd_pkg.
module snsd_quant #(
    parameter int DONE = 7
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  snsd_pkg::t_seq                         i_seq,
    input  logic signed [snsd_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic [39:0]                            i_scale,
    input  logic [37:0]                            i_recip,
    input  logic signed [snsd_pkg::ACC_W-1:0]      i_acc,
    output logic signed [snsd_pkg::SAMPLE_BITS-1:0] o_res
);

    localparam int SB  = snsd_pkg::SAMPLE_BITS;
    localparam int XSH = SB - 17;
    localparam int unsigned XSR = (XSH >= 0) ? XSH : 0;
    localparam int unsigned XSL = (XSH < 0) ? -XSH : 0;
    localparam int unsigned OSH = 41 - SB;
    localparam logic signed [63:0] OMAX = (64'sd1 <<< (SB - 1)) - 64'sd1;
    localparam logic signed [63:0] OMIN = -(64'sd1 <<< (SB - 1));
    localparam logic [snsd_pkg::CNT_W-1:0] S_MHI  = snsd_pkg::CNT_W'(1);
    localparam logic [snsd_pkg::CNT_W-1:0] S_X    = snsd_pkg::CNT_W'(2);
    localparam logic [snsd_pkg::CNT_W-1:0] S_SQ   = snsd_pkg::CNT_W'(3);
    localparam logic [snsd_pkg::CNT_W-1:0] S_CUBE = snsd_pkg::CNT_W'(4);
    localparam logic [snsd_pkg::CNT_W-1:0] S_ODD  = snsd_pkg::CNT_W'(5);
    localparam logic [snsd_pkg::CNT_W-1:0] S_T    = snsd_pkg::CNT_W'(6);
    localparam logic [snsd_pkg::CNT_W-1:0] S_Q    = snsd_pkg::CNT_W'(DONE);
    localparam logic [snsd_pkg::CNT_W-1:0] S_RHI  = snsd_pkg::CNT_W'(DONE + 1);
    localparam logic [snsd_pkg::CNT_W-1:0] S_RES  = snsd_pkg::CNT_W'(DONE + 2);

    logic signed [SB-1:0]  r_s;
    logic signed [39:0]    r_o, r_odd, r_last;
    logic signed [63:0]    r_m, r_x, r_c, r_t;
    logic signed [25:0]    r_q;
    logic signed [SB-1:0]  r_res;

    logic signed [40:0]    w_o1, w_o2;
    logic signed [27:0]    w_o20;
    logic signed [63:0]    w_xsum, w_xv, w_acc, w_qf, w_qc, w_cube, w_odd, w_prod, w_ps;

    always_comb begin
        // step the stored odd term by 0.97: down if positive and it stays >= 0, up if negative
        w_o1 = {r_odd[39], r_odd};
        if (w_o1 > 41'sd0) w_o1 = w_o1 - snsd_pkg::K_097;
        w_o2 = w_o1;
        if (w_o2 < 41'sd0) w_o2 = w_o2 + snsd_pkg::K_097;

        w_o20  = 28'(r_o >>> 12);
        w_xsum = (r_m <<< 20) + (r_s * $signed({1'b0, i_scale[19:0]}));
        w_xv   = (w_xsum >>> XSR) <<< XSL;
        w_cube = 64'($signed(r_c[43:0]) * snsd_pkg::K_0475) >>> 8;
        w_odd  = {{24{r_o[39]}}, r_o} - w_cube + {{24{r_last[39]}}, r_last};
        w_acc  = {{(64-snsd_pkg::ACC_W){i_acc[snsd_pkg::ACC_W-1]}}, i_acc} + r_x + r_t;
        w_qf   = w_acc >>> 32;
        w_qc   = w_qf;
        if (w_qc > snsd_pkg::LEVEL_LIM)  w_qc = snsd_pkg::LEVEL_LIM;
        if (w_qc < -snsd_pkg::LEVEL_LIM) w_qc = -snsd_pkg::LEVEL_LIM;
        w_prod = ((r_m <<< 19) + (r_q * $signed({1'b0, i_recip[18:0]}))) >>> OSH;
        w_ps   = w_prod;
        if (w_ps > OMAX) w_ps = OMAX;
        if (w_ps < OMIN) w_ps = OMIN;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_odd  <= '0;
            r_last <= '0;
        end else if (i_seq.run) begin
            if (i_seq.cnt == S_ODD) begin
                r_odd <= snsd_pkg::sat40(w_odd);
            end
            if (i_seq.cnt == S_Q) begin
                r_last <= snsd_pkg::sat40((w_qf <<< 32) - r_x);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_seq.load) begin
            r_s <= i_sample;
            r_o <= w_o2[39:0];
        end
        if (i_seq.run) begin
            case (i_seq.cnt)
                S_MHI:   r_m <= 64'(r_s * $signed({1'b0, i_scale[39:20]}));
                S_X:     r_x <= w_xv;
                S_SQ:    r_c <= 64'(w_o20 * w_o20) >>> 20;
                S_CUBE:  r_c <= 64'($signed(r_c[35:0]) * w_o20) >>> 20;
                S_T:     r_t <= 64'(r_odd * snsd_pkg::K_0475) >>> 20;
                S_Q:     r_q <= w_qc[25:0];
                S_RHI:   r_m <= 64'(r_q * $signed({1'b0, i_recip[37:19]}));
                S_RES:   r_res <= w_ps[SB-1:0];
                default: ;
            endcase
        end
    end

    assign o_res = r_res;

endmodule

/* src/stereo_noise_shaped_dither.sv */
// Top level of the stereo noise-shaped dither requantizer: register port,
// sequencer, two shaper chains of snsd_cell and two snsd_quant back ends.
// Depends on snsd_pkg, snsd_cell and snsd_quant.
//
// One stereo pair is taken at a time. A pair's result becomes valid once the
// shaper chain and the back-end steps are done, and the next pair can be
// accepted in the same cycle as that result becomes valid; the run is paced by
// the shaper chain, which moves one stage per cycle, and by the single
// multiplier step per cycle of each back end. Input ready stays low from
// acceptance until the result has moved into the output register; a waiting
// result only stalls the end of the next pair. The generators restart from the
// seed reset values on every reset; seed writes are stored and read back.
// Registers sit at byte addresses 0, 8, 16 and 24.
module stereo_noise_shaped_dither #(
    parameter int SHAPER_STAGES = snsd_pkg::STAGES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  snsd_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output snsd_pkg::t_out                      o_out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [snsd_pkg::ADDR_W-1:0]         paddr,
    input  logic [snsd_pkg::DATA_W-1:0]         pwdata,
    output logic [snsd_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    localparam int DONE = (SHAPER_STAGES > 7) ? SHAPER_STAGES : 7;
    localparam int ACC_W = snsd_pkg::ACC_W;
    localparam logic [snsd_pkg::CNT_W-1:0] CNT_END = snsd_pkg::CNT_W'(DONE + 2);
    localparam logic [snsd_pkg::CNT_W-1:0] CNT_DONE = snsd_pkg::CNT_W'(DONE);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    t_state                  r_state;
    logic [snsd_pkg::CNT_W-1:0] r_cnt;
    logic [39:0]             r_scale;
    logic [37:0]             r_recip;
    logic [31:0]             r_seed_l, r_seed_r;
    logic [31:0]             r_rng_l, r_rng_r;
    logic                    r_be;
    logic                    r_ovld;
    snsd_pkg::t_out          r_out;
    snsd_pkg::t_seq          w_seq;
    logic                    w_acc_in, w_wr, w_take;
    snsd_pkg::t_reg          w_idx;
    logic signed [31:0]      w_nz_l, w_nz_r;

    logic                    w_vl [SHAPER_STAGES+1];
    logic                    w_vr [SHAPER_STAGES+1];
    logic signed [ACC_W-1:0] w_al [SHAPER_STAGES+1];
    logic signed [ACC_W-1:0] w_ar [SHAPER_STAGES+1];
    logic [31:0]             w_rl [SHAPER_STAGES+1];
    logic [31:0]             w_rr [SHAPER_STAGES+1];
    logic signed [snsd_pkg::SAMPLE_BITS-1:0] w_res_l, w_res_r;

    assign w_acc_in  = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_take    = (r_state == ST_FIN) && (!r_ovld || i_out_ready);
    assign w_seq     = '{load: w_acc_in, run: (r_state == ST_RUN), cnt: r_cnt};
    assign w_idx     = snsd_pkg::t_reg'(paddr[4:3]);
    assign w_wr      = psel && penable && pwrite;
    assign pready    = 1'b1;

    assign w_nz_l = snsd_pkg::noise(r_rng_l);
    assign w_nz_r = snsd_pkg::noise(r_rng_r);
    assign w_vl[0] = w_acc_in;
    assign w_vr[0] = w_acc_in;
    assign w_al[0] = {{(ACC_W-32){w_nz_l[31]}}, w_nz_l};
    assign w_ar[0] = {{(ACC_W-32){w_nz_r[31]}}, w_nz_r};
    assign w_rl[0] = r_rng_l;
    assign w_rr[0] = r_rng_r;

    for (genvar k = 0; k < SHAPER_STAGES; k++) begin : g_chain
        snsd_cell #(.LAST(k == SHAPER_STAGES - 1)) u_cell_l (
            .i_clk (i_clk), .i_rst_n (i_rst_n),
            .i_vld (w_vl[k]), .i_acc (w_al[k]), .i_rng (w_rl[k]),
            .o_vld (w_vl[k+1]), .o_acc (w_al[k+1]), .o_rng (w_rl[k+1])
        );
        snsd_cell #(.LAST(k == SHAPER_STAGES - 1)) u_cell_r (
            .i_clk (i_clk), .i_rst_n (i_rst_n),
            .i_vld (w_vr[k]), .i_acc (w_ar[k]), .i_rng (w_rr[k]),
            .o_vld (w_vr[k+1]), .o_acc (w_ar[k+1]), .o_rng (w_rr[k+1])
        );
    end

    snsd_quant #(.DONE(DONE)) u_quant_l (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_seq (w_seq),
        .i_sample (i_in_data.left_sample), .i_scale (r_scale), .i_recip (r_recip),
        .i_acc (w_al[SHAPER_STAGES]), .o_res (w_res_l)
    );

    snsd_quant #(.DONE(DONE)) u_quant_r (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_seq (w_seq),
        .i_sample (i_in_data.right_sample), .i_scale (r_scale), .i_recip (r_recip),
        .i_acc (w_ar[SHAPER_STAGES]), .o_res (w_res_r)
    );

    always_comb begin
        case (w_idx)
            snsd_pkg::REG_SCALE:  prdata = {24'd0, r_scale};
            snsd_pkg::REG_RECIP:  prdata = {26'd0, r_recip};
            snsd_pkg::REG_SEED_L: prdata = {32'd0, r_seed_l};
            snsd_pkg::REG_SEED_R: prdata = {32'd0, r_seed_r};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= snsd_pkg::SCALE_RST;
            r_recip  <= snsd_pkg::RECIP_RST;
            r_seed_l <= snsd_pkg::SEED_L_RST;
            r_seed_r <= snsd_pkg::SEED_R_RST;
        end else if (w_wr) begin
            case (w_idx)
                snsd_pkg::REG_SCALE:  r_scale  <= pwdata[39:0];
                snsd_pkg::REG_RECIP:  r_recip  <= pwdata[37:0];
                snsd_pkg::REG_SEED_L: r_seed_l <= pwdata[31:0];
                snsd_pkg::REG_SEED_R: r_seed_r <= pwdata[31:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_rng_l <= snsd_pkg::SEED_L_RST;
            r_rng_r <= snsd_pkg::SEED_R_RST;
            r_ovld  <= 1'b0;
        end else begin
            r_ovld <= w_take || (r_ovld && !i_out_ready);
            case (r_state)
                ST_IDLE: begin
                    if (w_acc_in) begin
                        r_cnt   <= snsd_pkg::CNT_W'(1);
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_cnt <= r_cnt + snsd_pkg::CNT_W'(1);
                    // advance each generator once more past the chain end
                    if (r_cnt == CNT_DONE) begin
                        r_rng_l <= snsd_pkg::xs_step(w_rl[SHAPER_STAGES]);
                        r_rng_r <= snsd_pkg::xs_step(w_rr[SHAPER_STAGES]);
                    end
                    if (r_cnt == CNT_END) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_take) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_in) begin
            r_be <= i_in_data.block_end;
        end
        if (w_take) begin
            r_out <= '{left_dithered: w_res_l, right_dithered: w_res_r, block_end_out: r_be};
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out_data  = r_out;

endmodule

/* src/snsd_check.sv */
// Port-level checker for stereo_noise_shaped_dither, bound to the top level.
// Depends on snsd_pkg.
module snsd_check (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input snsd_pkg::t_out o_out_data
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("reset left a result or a busy input");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while busy");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid))
        else $error("result appeared one cycle after request");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind stereo_noise_shaped_dither snsd_check u_snsd_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
